// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/rfc_pkg.sv =====
// Types, codes and constants of the reciprocal frequency counter.
package rfc_pkg;

   localparam int TIMER_BITS_DEF     = 16;
   localparam int OVERFLOW_LIMIT_DEF = 255;

   localparam int PERIOD_W  = 14;
   localparam int CAP_FIELD_W = 16;
   localparam int FREQ_W    = 32;
   localparam int PROD_W    = FREQ_W + PERIOD_W;
   localparam int CSR_DW    = 32;
   localparam int CSR_AW    = 3;

   localparam logic [PERIOD_W-1:0] MAX_PERIODS     = PERIOD_W'(10000);
   localparam logic [PERIOD_W-1:0] PERIOD_RESET    = PERIOD_W'(1000);
   localparam logic [FREQ_W-1:0]   REF_CLOCK_RESET = FREQ_W'(84000000);
   localparam logic [FREQ_W-1:0]   FREQ_SAT        = '1;

   localparam logic [1:0] MODE_START    = 2'd0;
   localparam logic [1:0] MODE_CAPTURE  = 2'd1;
   localparam logic [1:0] MODE_OVERFLOW = 2'd2;

   localparam logic REG_PERIOD = 1'b0;
   localparam logic REG_REF    = 1'b1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_NO_FREQ = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT_FIRST,
      PH_WAIT_SPAN,
      PH_MEASURE
   } phase_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_MUL,
      SQ_PREP,
      SQ_DIV,
      SQ_DONE
   } seq_type;

endpackage

// ===== sv/reciprocal_frequency_counter.sv =====
// Reciprocal frequency counter: event decoder, divide step unit and result register.
//
// Start, overflow and most capture beats are accepted without holding off later beats.
// The capture beat that closes a measurement starts a sequence: the beat is accepted,
// ref_clock_hz * period_count is formed, one range check saturates the result, 32 steps of
// the single restoring subtract-and-shift divide unit run, and the result is handed
// to the output register; req_stall stays high while the sequence runs. A quotient that
// saturates skips the divide steps. The hand-off repeats while the output register is
// full and stalled. No beat is accepted while the sequence runs, and a beat that produces
// an immediate no-frequency result is also held off while the output register is full
// and stalled. Configuration registers sit behind the csr_ port at byte addresses 0
// (period_count) and 4 (ref_clock_hz).
module reciprocal_frequency_counter
   import rfc_pkg::*;
#(
   parameter int TIMER_BITS     = TIMER_BITS_DEF,
   parameter int OVERFLOW_LIMIT = OVERFLOW_LIMIT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_mode,
   input  logic [CAP_FIELD_W-1:0] req_capture_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [FREQ_W-1:0]      rsp_frequency,
   output logic                   rsp_status,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_AW-1:0]      csr_paddr,
   input  logic [CSR_DW-1:0]      csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);

   localparam int CAP_W = (TIMER_BITS < CAP_FIELD_W) ? TIMER_BITS : CAP_FIELD_W;
   localparam int OVF_W = $clog2(OVERFLOW_LIMIT + 1);
   localparam int CNT_W = $clog2(FREQ_W);
   localparam int SPAN_W = 16;

   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [FREQ_W-1:0]   ref_clock_ff, ref_clock_in;

   phase_type           phase_ff, phase_in;
   logic [PERIOD_W-1:0] edges_ff, edges_in;
   logic [CAP_W-1:0]    first_ff, first_in;
   logic [OVF_W-1:0]    tot_ovf_ff, tot_ovf_in;
   logic [SPAN_W-1:0]   span_ovf_ff, span_ovf_in;

   seq_type             seq_ff, seq_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [FREQ_W-1:0]   divisor_ff, divisor_in;
   logic [FREQ_W-1:0]   rem_ff, rem_in;
   logic [FREQ_W-1:0]   quo_ff, quo_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [FREQ_W-1:0]   rsp_freq_ff, rsp_freq_in;
   logic                rsp_status_ff, rsp_status_in;

   logic                csr_write;
   logic                accept;
   logic                out_free;
   logic                emit_now;
   logic                load_out;
   logic                period_ok;
   logic [PERIOD_W-1:0] edges_inc;
   logic [OVF_W-1:0]    tot_inc;
   logic [CAP_W-1:0]    cap;
   logic [63:0]         span_sh;
   logic [FREQ_W-1:0]   elapsed;
   logic [FREQ_W:0]     div_trial;
   logic [FREQ_W+1:0]   div_diff;
   logic                div_ge;
   logic                sat;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[2])
         REG_PERIOD: csr_prdata = CSR_DW'(period_ff);
         REG_REF:    csr_prdata = ref_clock_ff;
         default:    csr_prdata = '0;
      endcase
   end

   always_comb begin
      period_in    = period_ff;
      ref_clock_in = ref_clock_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_PERIOD: period_in    = csr_pwdata[PERIOD_W-1:0];
            REG_REF:    ref_clock_in = csr_pwdata[FREQ_W-1:0];
            default:    period_in    = period_ff;
         endcase
      end
   end

   // event decode
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign period_ok = (period_ff != '0) && (period_ff <= MAX_PERIODS);
   assign edges_inc = edges_ff + 1'b1;
   assign tot_inc   = tot_ovf_ff + 1'b1;
   assign cap       = req_capture_value[CAP_W-1:0];
   assign span_sh   = {{(64-SPAN_W){1'b0}}, span_ovf_ff} << TIMER_BITS;
   assign elapsed   = span_sh[FREQ_W-1:0] + FREQ_W'(cap) - FREQ_W'(first_ff);

   always_comb begin
      emit_now = 1'b0;
      unique case (req_mode)
         MODE_START:    emit_now = !period_ok;
         MODE_CAPTURE:  emit_now = (phase_ff == PH_MEASURE)
                                   && (!period_ok
                                       || ((edges_inc >= period_ff) && (elapsed == '0)));
         MODE_OVERFLOW: emit_now = (phase_ff != PH_IDLE)
                                   && (tot_inc >= OVF_W'(OVERFLOW_LIMIT));
         default:       emit_now = 1'b0;
      endcase
   end

   assign req_stall = (seq_ff != SQ_IDLE) || (emit_now && !out_free);
   assign accept    = req_valid && !req_stall;

   // divide step unit
   assign div_trial = {rem_ff, quo_ff[FREQ_W-1]};
   assign div_diff  = {1'b0, div_trial} - {2'b0, divisor_ff};
   assign div_ge    = !div_diff[FREQ_W+1];
   assign sat       = {{(FREQ_W-PERIOD_W){1'b0}}, prod_ff[PROD_W-1:FREQ_W]} >= divisor_ff;

   always_comb begin
      phase_in      = phase_ff;
      edges_in      = edges_ff;
      first_in      = first_ff;
      tot_ovf_in    = tot_ovf_ff;
      span_ovf_in   = span_ovf_ff;
      seq_in        = seq_ff;
      cnt_in        = cnt_ff;
      prod_in       = prod_ff;
      divisor_in    = divisor_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      load_out      = 1'b0;
      rsp_freq_in   = rsp_freq_ff;
      rsp_status_in = rsp_status_ff;

      if (accept) begin
         if (emit_now) begin
            load_out      = 1'b1;
            rsp_freq_in   = '0;
            rsp_status_in = STATUS_NO_FREQ;
         end
         unique case (req_mode)
            MODE_START: begin
               edges_in    = '0;
               first_in    = '0;
               tot_ovf_in  = '0;
               span_ovf_in = '0;
               phase_in    = period_ok ? PH_WAIT_FIRST : PH_IDLE;
            end
            MODE_CAPTURE: begin
               unique case (phase_ff)
                  PH_WAIT_FIRST: phase_in = PH_WAIT_SPAN;
                  PH_WAIT_SPAN: begin
                     first_in    = cap;
                     edges_in    = '0;
                     span_ovf_in = '0;
                     phase_in    = PH_MEASURE;
                  end
                  PH_MEASURE: begin
                     if (!period_ok) begin
                        phase_in = PH_IDLE;
                     end else begin
                        edges_in = edges_inc;
                        if (edges_inc >= period_ff) begin
                           phase_in = PH_IDLE;
                           if (elapsed != '0) begin
                              divisor_in = elapsed;
                              seq_in     = SQ_MUL;
                           end
                        end
                     end
                  end
                  default: phase_in = phase_ff;
               endcase
            end
            MODE_OVERFLOW: begin
               if (phase_ff != PH_IDLE) begin
                  tot_ovf_in = tot_inc;
                  if (phase_ff == PH_MEASURE) begin
                     span_ovf_in = span_ovf_ff + 1'b1;
                  end
                  if (emit_now) begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            default: phase_in = phase_ff;
         endcase
      end

      unique case (seq_ff)
         SQ_IDLE: seq_in = seq_in;
         SQ_MUL: begin
            prod_in = PROD_W'(ref_clock_ff) * PROD_W'(period_ff);
            seq_in  = SQ_PREP;
         end
         SQ_PREP: begin
            if (sat) begin
               quo_in = FREQ_SAT;
               seq_in = SQ_DONE;
            end else begin
               rem_in = FREQ_W'(prod_ff[PROD_W-1:FREQ_W]);
               quo_in = prod_ff[FREQ_W-1:0];
               cnt_in = '0;
               seq_in = SQ_DIV;
            end
         end
         SQ_DIV: begin
            rem_in = div_ge ? div_diff[FREQ_W-1:0] : div_trial[FREQ_W-1:0];
            quo_in = {quo_ff[FREQ_W-2:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(FREQ_W - 1)) begin
               seq_in = SQ_DONE;
            end
         end
         SQ_DONE: begin
            if (out_free) begin
               load_out      = 1'b1;
               rsp_freq_in   = quo_ff;
               rsp_status_in = STATUS_OK;
               seq_in        = SQ_IDLE;
            end
         end
         default: seq_in = SQ_IDLE;
      endcase

      rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= PERIOD_RESET;
         ref_clock_ff <= REF_CLOCK_RESET;
         phase_ff     <= PH_IDLE;
         edges_ff     <= '0;
         first_ff     <= '0;
         tot_ovf_ff   <= '0;
         span_ovf_ff  <= '0;
         seq_ff       <= SQ_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         ref_clock_ff <= ref_clock_in;
         phase_ff     <= phase_in;
         edges_ff     <= edges_in;
         first_ff     <= first_in;
         tot_ovf_ff   <= tot_ovf_in;
         span_ovf_ff  <= span_ovf_in;
         seq_ff       <= seq_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      divisor_ff    <= divisor_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      rsp_freq_ff   <= rsp_freq_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_frequency = rsp_freq_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ===== sv/rfc_checker.sv =====
// Port-level checker for the reciprocal frequency counter, bound to the top level.
`include "assert_macros.svh"

module rfc_checker
   import rfc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [FREQ_W-1:0] rsp_frequency,
   input logic              rsp_status,
   input logic              csr_pready
);

   `ASSERT_IMPL(a_nofreq, clock, reset, rsp_valid && rsp_status == STATUS_NO_FREQ, rsp_frequency == '0)
   `ASSERT_IMPL(a_pready_high, clock, reset, 1'b1, csr_pready)
   `ASSERT_NEXT(a_rsp_hold_valid, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_NEXT(a_rsp_hold_freq, clock, reset, rsp_valid && rsp_stall, $stable(rsp_frequency))
   `ASSERT_NEXT(a_rsp_hold_status, clock, reset, rsp_valid && rsp_stall, $stable(rsp_status))

endmodule

bind reciprocal_frequency_counter rfc_checker u_rfc_checker (.*);

// ===== bench/tb.sv =====
// Self-checking testbench for the reciprocal frequency counter.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rfc_pkg::*;

   localparam logic [1:0]        MODE_UNUSED  = 2'd3;
   localparam logic [CSR_AW-1:0] ADDR_PERIOD  = CSR_AW'(4 * int'(REG_PERIOD));
   localparam logic [CSR_AW-1:0] ADDR_REF     = CSR_AW'(4 * int'(REG_REF));
   localparam int                DRAIN_CYCLES = 50;
   localparam int                MAX_GAP      = 19;
   localparam int                RANDOM_BEATS = 1850;
   localparam int                LONG_HOLD    = 300;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic              status;
   } reading_type;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      logic [1:0]              mode;
      logic [CAP_FIELD_W-1:0]  cap;
      logic [CSR_AW-1:0]       addr;
      logic [CSR_DW-1:0]       data;
      bit                      typed;
      reading_type             want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_mode = MODE_START;
   logic [CAP_FIELD_W-1:0] req_capture_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [FREQ_W-1:0]      rsp_frequency;
   logic                   rsp_status;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]      csr_paddr = '0;
   logic [CSR_DW-1:0]      csr_pwdata = '0;
   logic [CSR_DW-1:0]      csr_prdata;
   logic                   csr_pready;

   reciprocal_frequency_counter uut (.*);

   always #10 clock = ~clock;

   // predictor state
   logic [PERIOD_W-1:0]    cfg_period = PERIOD_RESET;
   logic [FREQ_W-1:0]      cfg_ref = REF_CLOCK_RESET;
   phase_type              meas_phase = PH_IDLE;
   logic [PERIOD_W-1:0]    edge_count = '0;
   logic [CAP_FIELD_W-1:0] span_start = '0;
   int                     ovf_total = 0;
   logic [15:0]            span_ovf = '0;

   reading_type  pending_readings[$];
   stim_row_type dir_rows[$];
   int        errors = 0;
   int        n_beats = 0;
   int        n_readings = 0;
   int        n_no_freq = 0;
   int        n_saturated = 0;
   int        n_timeouts = 0;
   int        rsp_hold_req = 0;
   bit        burst = 1'b0;

   function automatic bit period_ok();
      return cfg_period != '0 && cfg_period <= MAX_PERIODS;
   endfunction

   function automatic void predict_reading(input logic [1:0] mode,
                                           input logic [CAP_FIELD_W-1:0] cap,
                                           output bit emit, output reading_type r,
                                           output bit ignored);
      logic [31:0] elapsed;
      logic [63:0] quot;
      emit = 1'b0;
      ignored = 1'b0;
      r.freq = '0;
      r.status = STATUS_NO_FREQ;
      case (mode)
         MODE_START: begin
            edge_count = '0;
            span_start = '0;
            ovf_total = 0;
            span_ovf = '0;
            if (!period_ok()) emit = 1'b1;
            else meas_phase = PH_WAIT_FIRST;
         end
         MODE_CAPTURE: begin
            case (meas_phase)
               PH_IDLE: ignored = 1'b1;
               PH_WAIT_FIRST: meas_phase = PH_WAIT_SPAN;
               PH_WAIT_SPAN: begin
                  span_start = cap;
                  edge_count = '0;
                  span_ovf = '0;
                  meas_phase = PH_MEASURE;
               end
               default: begin
                  if (!period_ok()) begin
                     emit = 1'b1;
                  end else begin
                     edge_count = edge_count + 1'b1;
                     if (edge_count >= cfg_period) begin
                        emit = 1'b1;
                        elapsed = {span_ovf, 16'h0000} + 32'(cap) - 32'(span_start);
                        if (elapsed != '0) begin
                           quot = 64'(cfg_ref) * 64'(cfg_period) / 64'(elapsed);
                           r.freq = (quot > 64'(FREQ_SAT)) ? FREQ_SAT : quot[31:0];
                           r.status = STATUS_OK;
                        end
                     end
                  end
               end
            endcase
         end
         MODE_OVERFLOW: begin
            if (meas_phase == PH_IDLE) begin
               ignored = 1'b1;
            end else begin
               ovf_total++;
               if (meas_phase == PH_MEASURE) span_ovf = span_ovf + 1'b1;
               if (ovf_total >= OVERFLOW_LIMIT_DEF) begin
                  emit = 1'b1;
                  n_timeouts++;
               end
            end
         end
         default: ignored = 1'b1;
      endcase
      if (emit) meas_phase = PH_IDLE;
   endfunction

   function automatic stim_row_type beat(input logic [1:0] mode, input logic [15:0] cap);
      stim_row_type row;
      row = '{ROW_BEAT, mode, cap, '0, '0, 1'b0, '0};
      return row;
   endfunction

   function automatic stim_row_type beat_exp(input logic [1:0] mode, input logic [15:0] cap,
                                             input logic [31:0] freq, input logic status);
      stim_row_type row;
      row = '{ROW_BEAT, mode, cap, '0, '0, 1'b1, {freq, status}};
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_AW-1:0] addr,
                                            input logic [31:0] data);
      stim_row_type row;
      row = '{ROW_CSR, MODE_START, '0, addr, data, 1'b0, '0};
      return row;
   endfunction

   function automatic logic [CAP_FIELD_W-1:0] pick_cap();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return span_start;
      if (r == 1) return '0;
      if (r == 2) return '1;
      return CAP_FIELD_W'($urandom);
   endfunction

   task automatic send_beat(input logic [1:0] mode, input logic [CAP_FIELD_W-1:0] cap,
                            input bit typed, input reading_type want);
      int          gap;
      bit          emit;
      bit          ignored;
      reading_type r;
      gap = burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_capture_value <= cap;
      do @(posedge clock); while (req_stall);
      predict_reading(mode, cap, emit, r, ignored);
      if (typed) pending_readings.push_back(want);
      else if (emit) pending_readings.push_back(r);
      if (!ignored) n_beats++;
   endtask

   // block idle: input quiet, all readings back, divider given time to finish
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic [CSR_AW-1:0] addr, input logic write,
                             input logic [31:0] data, output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_reg(input logic [CSR_AW-1:0] addr, input logic [31:0] data);
      logic [31:0] rd;
      logic [31:0] want;
      csr_access(addr, 1'b1, data, rd);
      if (addr == ADDR_PERIOD) cfg_period = data[PERIOD_W-1:0];
      else cfg_ref = data;
      want = (addr == ADDR_PERIOD) ? 32'(cfg_period) : cfg_ref;
      csr_access(addr, 1'b0, '0, rd);
      if (rd !== want) begin
         $display("%0t: csr readback at %0d expected %h, got %h", $time, addr, want, rd);
         errors++;
      end
   endtask

   task automatic retune();
      logic [31:0] period;
      logic [31:0] ref_hz;
      settle();
      case ($urandom_range(0, 19))
         0:       period = 0;
         1:       period = 32'(MAX_PERIODS);
         2:       period = 32'h3FFF;
         3:       period = $urandom_range(10001, 16382);
         4, 5:    period = $urandom_range(7, 40);
         6:       period = 1;
         default: period = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 9))
         0:       ref_hz = 1;
         1:       ref_hz = '1;
         2:       ref_hz = REF_CLOCK_RESET;
         3:       ref_hz = 0;
         default: ref_hz = $urandom;
      endcase
      set_reg(ADDR_PERIOD, ($urandom & ~32'h3FFF) | period);
      set_reg(ADDR_REF, ref_hz);
   endtask

   task automatic run_measurement();
      int steps;
      int pick;
      steps = 0;
      send_beat(MODE_START, CAP_FIELD_W'($urandom), 1'b0, '0);
      while (meas_phase != PH_IDLE && steps < 40) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) send_beat(MODE_CAPTURE, pick_cap(), 1'b0, '0);
         else if (pick < 95) send_beat(MODE_OVERFLOW, CAP_FIELD_W'($urandom), 1'b0, '0);
         else send_beat(MODE_UNUSED, CAP_FIELD_W'($urandom), 1'b0, '0);
         steps++;
      end
   endtask

   task automatic run_timeout();
      send_beat(MODE_START, CAP_FIELD_W'($urandom), 1'b0, '0);
      while (meas_phase != PH_IDLE) begin
         if (meas_phase != PH_MEASURE && $urandom_range(0, 9) == 0)
            send_beat(MODE_CAPTURE, CAP_FIELD_W'($urandom), 1'b0, '0);
         else
            send_beat(MODE_OVERFLOW, CAP_FIELD_W'($urandom), 1'b0, '0);
      end
   endtask

   // result side: random stall, or a long hold when asked
   initial begin : rsp_side
      int n;
      wait (!reset);
      forever begin
         if (rsp_hold_req > 0) begin
            n = rsp_hold_req;
            rsp_hold_req = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            n = 0;
         end else begin
            n = $urandom_range(0, MAX_GAP);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin : reading_check
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected beat, frequency %h status %b",
                     $time, rsp_frequency, rsp_status);
            errors++;
         end else begin
            want = pending_readings.pop_front();
            n_readings++;
            if (want.status == STATUS_NO_FREQ) n_no_freq++;
            else if (want.freq == FREQ_SAT) n_saturated++;
            if (rsp_frequency !== want.freq) begin
               $display("%0t: frequency expected %h, got %h", $time, want.freq, rsp_frequency);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %b, got %b", $time, want.status, rsp_status);
               errors++;
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      int pick;
      dir_rows = {
         csr_row(ADDR_PERIOD, 32'd0),
         beat_exp(MODE_START, 16'h0000, '0, STATUS_NO_FREQ),
         beat(MODE_CAPTURE, 16'hFFFF),
         beat(MODE_OVERFLOW, 16'h0000),
         beat(MODE_UNUSED, 16'hAAAA),
         csr_row(ADDR_PERIOD, 32'hFFFF_C002),
         csr_row(ADDR_REF, 32'hFFFF_FFFF),
         beat(MODE_START, 16'h0000),
         beat(MODE_CAPTURE, 16'h5555),
         beat(MODE_CAPTURE, 16'h0000),
         beat(MODE_CAPTURE, 16'h0000),
         beat_exp(MODE_CAPTURE, 16'h0001, FREQ_SAT, STATUS_OK),
         csr_row(ADDR_PERIOD, 32'd1),
         beat(MODE_START, 16'h0000),
         beat(MODE_OVERFLOW, 16'h0000),
         beat(MODE_CAPTURE, 16'h1234),
         beat(MODE_CAPTURE, 16'h8000),
         beat_exp(MODE_CAPTURE, 16'h8000, '0, STATUS_NO_FREQ),
         beat(MODE_START, 16'h0000),
         beat(MODE_CAPTURE, 16'hFFFF),
         beat(MODE_CAPTURE, 16'hFFFF),
         beat(MODE_OVERFLOW, 16'h0000),
         beat(MODE_CAPTURE, 16'h0000),
         csr_row(ADDR_PERIOD, 32'(MAX_PERIODS)),
         csr_row(ADDR_REF, 32'd1),
         beat(MODE_START, 16'h0000),
         beat(MODE_CAPTURE, 16'h0000),
         beat(MODE_CAPTURE, 16'h0100),
         beat(MODE_CAPTURE, 16'h0000),
         beat(MODE_CAPTURE, 16'hFFFF),
         csr_row(ADDR_PERIOD, 32'd1),
         beat(MODE_CAPTURE, 16'h0300),
         csr_row(ADDR_PERIOD, 32'd3),
         beat(MODE_START, 16'h0000),
         beat(MODE_CAPTURE, 16'h0000),
         beat(MODE_CAPTURE, 16'h0000),
         csr_row(ADDR_PERIOD, 32'h0000_2711),
         beat_exp(MODE_CAPTURE, 16'h0007, '0, STATUS_NO_FREQ)
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            settle();
            set_reg(dir_rows[i].addr, dir_rows[i].data);
         end else begin
            send_beat(dir_rows[i].mode, dir_rows[i].cap, dir_rows[i].typed,
                      dir_rows[i].want);
         end
      end

      // backpressure: hold the result side while short measurements keep coming
      settle();
      set_reg(ADDR_PERIOD, 32'd1);
      set_reg(ADDR_REF, REF_CLOCK_RESET);
      rsp_hold_req = LONG_HOLD;
      burst = 1'b1;
      repeat (6) begin
         send_beat(MODE_START, 16'h0000, 1'b0, '0);
         repeat (3) send_beat(MODE_CAPTURE, CAP_FIELD_W'($urandom), 1'b0, '0);
      end
      burst = 1'b0;
      settle();
      set_reg(ADDR_PERIOD, 32'd3);

      n_beats = 0;
      while (n_beats < RANDOM_BEATS) begin
         burst = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 4) == 0) retune();
         pick = $urandom_range(0, 99);
         if ((n_timeouts == 0 && period_ok()) || pick < 1) begin
            run_timeout();
         end else if (pick < 12) begin
            repeat ($urandom_range(3, 15))
               send_beat(2'($urandom), CAP_FIELD_W'($urandom), 1'b0, '0);
         end else begin
            run_measurement();
         end
      end

      req_valid <= 1'b0;
      for (int i = 0; i < 5000 && pending_readings.size() != 0; i++) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_readings.size() != 0) begin
         $display("%0t: %0d readings never arrived", $time, pending_readings.size());
         errors++;
      end

      $display("tb: %0d counted beats, %0d readings checked", n_beats, n_readings);
      $display("tb: %0d no-frequency, %0d saturated, %0d overflow timeouts",
               n_no_freq, n_saturated, n_timeouts);
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
